// File: sv/rbs_pkg.sv
// Shared types and constants for the ray/box slab test.
package rbs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int THR_W         = 17;
  localparam logic [THR_W-1:0] THR_RESET = 17'd1;
  localparam int DIV_STG       = 32;            // one quotient bit per stage
  localparam int DIV_LAT       = DIV_STG + 2;   // entry check, bit stages, saturate
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [31:0] box_low_x;
    logic signed [31:0] box_low_y;
    logic signed [31:0] box_low_z;
    logic signed [31:0] box_high_x;
    logic signed [31:0] box_high_y;
    logic signed [31:0] box_high_z;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] t_near;
    logic signed [31:0] t_far;
  } out_t;

  typedef struct packed {
    logic               par;
    logic               in_slab;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
  } lane_t;

endpackage

// File: sv/ray_box_slab_test.sv
// Ray against axis-aligned box, slab method, three axis lanes and a merge stage.
// The path from input beat to result runs through set-up, 34 divider stages and merge.
// Throughput: one beat per cycle while not stalled; each lane's dividers resolve one quotient bit per stage.
// The pipeline stalls as a whole only while a finished result waits on out_ready.
// Reset (rst_n, synchronous): clears valid bits, threshold returns to 1.
module ray_box_slab_test #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  rbs_pkg::in_t             in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rbs_pkg::out_t            out_data,
  input  logic                     cfg_we,
  input  logic [rbs_pkg::THR_W-1:0] cfg_wdata
);
  localparam int LAT = rbs_pkg::DIV_LAT + 2;

  logic [rbs_pkg::THR_W-1:0] thr_r;
  logic [LAT-1:0]            vld_r;
  logic                      en;
  rbs_pkg::lane_t            lx, ly, lz;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= rbs_pkg::THR_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_we) thr_r <= cfg_wdata;
      if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .en(en), .thr(thr_r), .lo(in_data.box_low_x), .hi(in_data.box_high_x),
    .org(in_data.origin_x), .dir(in_data.dir_x), .res(lx)
  );

  rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .en(en), .thr(thr_r), .lo(in_data.box_low_y), .hi(in_data.box_high_y),
    .org(in_data.origin_y), .dir(in_data.dir_y), .res(ly)
  );

  rbs_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .en(en), .thr(thr_r), .lo(in_data.box_low_z), .hi(in_data.box_high_z),
    .org(in_data.origin_z), .dir(in_data.dir_z), .res(lz)
  );

  rbs_merge u_merge (
    .clk(clk), .en(en), .lx(lx), .ly(ly), .lz(lz), .res(out_data)
  );

endmodule

// File: sv/rbs_div.sv
// Pipelined restoring divider: one quotient bit per stage, saturating signed result.
module rbs_div #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [33+FRAC_BITS-1:0] num_mag,
  input  logic [31:0]            den,
  input  logic                   neg,
  output logic signed [31:0]     t
);
  localparam int RW  = 64;
  localparam int STG = rbs_pkg::DIV_STG;

  logic [RW-1:0] rem_r [0:STG-1];
  logic [31:0]   den_r [0:STG-1];
  logic [31:0]   q_r   [0:STG];
  logic          neg_r [0:STG];
  logic          ovf_r [0:STG];
  logic signed [31:0] t_r;
  logic signed [31:0] t_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num_mag);
      den_r[0] <= den;
      neg_r[0] <= neg;
      q_r[0]   <= '0;
      // quotient of 2^32 or more cannot fit
      ovf_r[0] <= (RW'(num_mag) >> 32) >= RW'(den);
    end
  end

  for (genvar j = 1; j <= STG; j++) begin : g_stg
    localparam int B = STG - j;
    logic [32:0]   part;
    logic          ge;
    logic [31:0]   q_nxt;

    always_comb begin
      part     = rem_r[j-1][B +: 33];
      ge       = part >= {1'b0, den_r[j-1]};
      q_nxt    = q_r[j-1];
      q_nxt[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]   <= q_nxt;
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < STG) begin : g_keep
      logic [RW-1:0] rem_nxt;

      always_comb begin
        rem_nxt = rem_r[j-1];
        if (ge) begin
          rem_nxt[B +: 33] = part - {1'b0, den_r[j-1]};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= rem_nxt;
          den_r[j] <= den_r[j-1];
        end
      end
    end
  end

  always_comb begin
    if (ovf_r[STG]) begin
      t_nxt = neg_r[STG] ? rbs_pkg::T_MIN : rbs_pkg::T_MAX;
    end else if (neg_r[STG]) begin
      t_nxt = (q_r[STG] > 32'h8000_0000) ? rbs_pkg::T_MIN : -$signed(q_r[STG]);
    end else begin
      t_nxt = q_r[STG][31] ? rbs_pkg::T_MAX : $signed(q_r[STG]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
    end
  end

  assign t = t_r;

endmodule

// File: sv/rbs_lane.sv
// One axis lane: slab set-up, two slab distance dividers, flag delay line.
module rbs_lane #(
  parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [rbs_pkg::THR_W-1:0] thr,
  input  logic signed [31:0]       lo,
  input  logic signed [31:0]       hi,
  input  logic signed [31:0]       org,
  input  logic signed [31:0]       dir,
  output rbs_pkg::lane_t           res
);
  localparam int NW  = 33 + FRAC_BITS;
  localparam int LAT = rbs_pkg::DIV_LAT;

  logic signed [32:0] dlo, dhi;
  logic [32:0]        mlo, mhi;
  logic [31:0]        dmag;
  logic [NW-1:0]      nlo_r, nhi_r;
  logic [31:0]        dmag_r;
  logic               neglo_r, neghi_r;
  logic               par_r [0:LAT];
  logic               ins_r [0:LAT];
  logic signed [31:0] t1, t2;

  always_comb begin
    dlo  = {lo[31], lo} - {org[31], org};
    dhi  = {hi[31], hi} - {org[31], org};
    mlo  = dlo[32] ? 33'(-dlo) : 33'(dlo);
    mhi  = dhi[32] ? 33'(-dhi) : 33'(dhi);
    dmag = dir[31] ? 32'(-dir) : 32'(dir);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlo_r   <= NW'(mlo) << FRAC_BITS;
      nhi_r   <= NW'(mhi) << FRAC_BITS;
      dmag_r  <= dmag;
      neglo_r <= dlo[32] ^ dir[31];
      neghi_r <= dhi[32] ^ dir[31];
      par_r[0] <= (dir == 32'sd0) || (dmag < 32'(thr));
      ins_r[0] <= !((org < lo) || (org > hi));
    end
  end

  for (genvar k = 1; k <= LAT; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (en) begin
        par_r[k] <= par_r[k-1];
        ins_r[k] <= ins_r[k-1];
      end
    end
  end

  rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
    .clk(clk), .en(en), .num_mag(nlo_r), .den(dmag_r), .neg(neglo_r), .t(t1)
  );

  rbs_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
    .clk(clk), .en(en), .num_mag(nhi_r), .den(dmag_r), .neg(neghi_r), .t(t2)
  );

  always_comb begin
    res.par     = par_r[LAT];
    res.in_slab = ins_r[LAT];
    res.t1      = t1;
    res.t2      = t2;
  end

endmodule

// File: sv/rbs_merge.sv
// Folds the three lane results in x, y, z order into the output register.
module rbs_merge (
  input  logic           clk,
  input  logic           en,
  input  rbs_pkg::lane_t lx,
  input  rbs_pkg::lane_t ly,
  input  rbs_pkg::lane_t lz,
  output rbs_pkg::out_t  res
);
  rbs_pkg::lane_t     ln [0:2];
  rbs_pkg::out_t      res_r, res_nxt;
  logic signed [31:0] a, b, near, far;
  logic               hit;

  assign ln[0] = lx;
  assign ln[1] = ly;
  assign ln[2] = lz;

  always_comb begin
    near = rbs_pkg::T_MIN;
    far  = rbs_pkg::T_MAX;
    hit  = 1'b1;
    a    = '0;
    b    = '0;
    for (int i = 0; i < 3; i++) begin
      if (hit) begin
        if (ln[i].par) begin
          hit = ln[i].in_slab;
        end else begin
          a = (ln[i].t1 > ln[i].t2) ? ln[i].t2 : ln[i].t1;
          b = (ln[i].t1 > ln[i].t2) ? ln[i].t1 : ln[i].t2;
          if (a > near) near = a;
          if (b < far) far = b;
          hit = !((near > far) || (far < 32'sd0));
        end
      end
    end
    res_nxt.hit    = hit;
    res_nxt.t_near = near;
    res_nxt.t_far  = far;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
